@@ rtl/acpa_pkg.sv @@
// ----------------------------------------------------------------------------
// acpa_pkg: shared types and codes of the chunk pool allocator
// Command and result layouts, table entry layouts, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package acpa_pkg;

   // operation codes carried in func
   localparam logic [1:0] FUNC_QUEUE    = 2'd0;
   localparam logic [1:0] FUNC_FREE     = 2'd1;
   localparam logic [1:0] FUNC_FINALIZE = 2'd2;
   localparam logic [1:0] FUNC_SEARCH   = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_UNKNOWN   = 3'd2;
   localparam logic [2:0] ST_NO_SPACE  = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;

   // widths of fields and of internal sums
   localparam int SIZE_W = 21;
   localparam int ID_W   = 32;
   localparam int POOL_W = 26;
   localparam int START_W = 27;
   localparam int ASZ_W  = 22;
   localparam int SUM_W  = 28;
   localparam int REQ_W  = 56;
   localparam int RSP_W  = 112;
   localparam logic [POOL_W-1:0] POOL_MAX = '1;

   typedef struct packed {
      logic [1:0]        func;
      logic [SIZE_W-1:0] size;
      logic [ID_W-1:0]   id;
   } cmd_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [ID_W-1:0]          id;
      logic signed [START_W-1:0] start;
      logic [SIZE_W-1:0]        size;
      logic                     last;
   } res_type;

   // placed table entry; asz is the size rounded to the next aligned end
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [POOL_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic [ASZ_W-1:0]  asz;
   } placed_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
      logic [ASZ_W-1:0]  asz;
   } pending_type;

endpackage
`default_nettype wire

@@ rtl/acpa_front.sv @@
// ----------------------------------------------------------------------------
// acpa_front: request intake
// Accepts request transfers, decodes them into commands and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module acpa_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [acpa_pkg::REQ_W-1:0]   req_tdata,  // func[1:0], size_dw[22:2], item_id[54:23]
   output logic                         cmd_valid,
   output acpa_pkg::cmd_type            cmd,
   input  wire                          cmd_pop
);

   acpa_pkg::cmd_type fifo_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   acpa_pkg::cmd_type dec;
   logic              push;

   // decode the packed request
   always_comb begin
      dec.func = req_tdata[1:0];
      dec.size = req_tdata[22:2];
      dec.id   = req_tdata[54:23];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = fifo_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (cmd_pop && cmd_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the decoded command
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

@@ rtl/acpa_back.sv @@
// ----------------------------------------------------------------------------
// acpa_back: allocation engine
// Sequencer over the placed and pending tables; walks entries one at a time
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module acpa_back #(
   parameter int MAX_CHUNKS  = 32,
   parameter int ALIGN_DW    = 1024,
   parameter int MIN_POOL_DW = 16384
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          cmd_valid,
   input  acpa_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [acpa_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   localparam int CW      = $clog2(MAX_CHUNKS + 1);
   localparam int AW      = $clog2(MAX_CHUNKS);
   localparam int SW      = acpa_pkg::SUM_W;
   localparam int DIV_SH  = 22 + $clog2(ALIGN_DW);
   localparam int RECIP_W = 24;
   localparam longint RECIP = ((64'sd1 <<< DIV_SH) + ALIGN_DW - 1) / ALIGN_DW;
   localparam int PROD_W  = RECIP_W + acpa_pkg::SIZE_W;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_Q_DIV   = 5'd1;
   localparam logic [4:0] S_Q_MUL   = 5'd2;
   localparam logic [4:0] S_EMIT    = 5'd3;
   localparam logic [4:0] S_FP_RD   = 5'd4;
   localparam logic [4:0] S_FP_CHK  = 5'd5;
   localparam logic [4:0] S_FPS_RD  = 5'd6;
   localparam logic [4:0] S_FPS_WT  = 5'd7;
   localparam logic [4:0] S_FPS_WR  = 5'd8;
   localparam logic [4:0] S_FQ_RD   = 5'd9;
   localparam logic [4:0] S_FQ_CHK  = 5'd10;
   localparam logic [4:0] S_FQS_RD  = 5'd11;
   localparam logic [4:0] S_FQS_WT  = 5'd12;
   localparam logic [4:0] S_FQS_WR  = 5'd13;
   localparam logic [4:0] S_NP_RD   = 5'd14;
   localparam logic [4:0] S_NP_ACC  = 5'd15;
   localparam logic [4:0] S_NQ_RD   = 5'd16;
   localparam logic [4:0] S_NQ_ACC  = 5'd17;
   localparam logic [4:0] S_N_DEC   = 5'd18;
   localparam logic [4:0] S_NC_RD   = 5'd19;
   localparam logic [4:0] S_NC_WR   = 5'd20;
   localparam logic [4:0] S_NA_RD   = 5'd21;
   localparam logic [4:0] S_NA_WR   = 5'd22;
   localparam logic [4:0] S_NO_RD   = 5'd23;
   localparam logic [4:0] S_NO_EMIT = 5'd24;
   localparam logic [4:0] S_G_RD    = 5'd25;
   localparam logic [4:0] S_G_CHK   = 5'd26;

   // tables
   acpa_pkg::placed_type  placed_mem  [MAX_CHUNKS];
   acpa_pkg::pending_type pending_mem [MAX_CHUNKS];
   acpa_pkg::placed_type  pl_q_ff;
   acpa_pkg::pending_type pn_q_ff;
   logic                  pl_we, pn_we;
   logic [AW-1:0]         pl_wa, pn_wa;
   acpa_pkg::placed_type  pl_wd;
   acpa_pkg::pending_type pn_wd;

   // control and bookkeeping
   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pc_ff, pc_in;
   logic [CW-1:0] qc_ff, qc_in;
   logic [31:0]   nid_ff, nid_in;
   logic [acpa_pkg::POOL_W-1:0] pool_ff, pool_in;
   logic          holes_ff, holes_in;
   logic          ovalid_ff, ovalid_in;

   // payload registers
   acpa_pkg::cmd_type cmd_ff, cmd_in;
   acpa_pkg::res_type res_ff, res_in;
   acpa_pkg::res_type ores_ff;
   logic [acpa_pkg::POOL_W-1:0] opool_ff;
   logic [SW-1:0] acc_ff, acc_in;
   logic [SW-1:0] part_ff, part_in;
   logic [SW-1:0] lend_ff, lend_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [acpa_pkg::SIZE_W-1:0] q_ff, q_in;

   // datapath helpers
   logic [PROD_W-1:0]  div_prod;
   logic [38:0]        asz_full;
   logic [CW:0]        used_sum;
   logic [CW-1:0]      idx_inc;
   logic [SW-1:0]      need;
   logic [SW:0]        newpool;
   logic signed [SW:0] gap_diff;
   logic signed [SW:0] tail_diff;
   logic [SW-1:0]      pl_end;
   logic               out_free, out_load;
   acpa_pkg::res_type  emit_res;

   assign out_free = !ovalid_ff || rsp_tready;
   assign idx_inc  = idx_ff + 1'b1;
   assign used_sum = {1'b0, pc_ff} + {1'b0, qc_ff};
   assign div_prod = PROD_W'(cmd_ff.size) * PROD_W'(RECIP[RECIP_W-1:0]);
   assign asz_full = (39'(q_ff) + 39'd1) * 39'(ALIGN_DW);
   assign need     = acc_ff + part_ff;
   assign pl_end   = SW'(pl_q_ff.start) + SW'(pl_q_ff.asz);
   assign gap_diff = $signed({3'b0, pl_q_ff.start}) - $signed({1'b0, pos_ff});
   assign tail_diff = $signed({3'b0, pool_ff}) - $signed({1'b0, pos_ff});

   // grow the pool to at least the needed size
   always_comb begin
      newpool = {3'b0, pool_ff};
      if ({3'b0, pool_ff} < {1'b0, need}) begin
         if (pool_ff == '0) begin
            newpool = (need > SW'(MIN_POOL_DW)) ? {1'b0, need} : (SW + 1)'(MIN_POOL_DW);
         end else begin
            newpool = {1'b0, need} + (SW + 1)'(ALIGN_DW);
         end
      end
   end

   // select the result that goes out this cycle
   always_comb begin
      emit_res = res_ff;
      if (state_ff == S_NO_EMIT) begin
         emit_res.status = acpa_pkg::ST_OK;
         emit_res.id     = pl_q_ff.id;
         emit_res.start  = $signed({1'b0, pl_q_ff.start});
         emit_res.size   = pl_q_ff.size;
         emit_res.last   = (idx_inc == pc_ff);
      end
   end

   assign out_load = out_free && ((state_ff == S_EMIT) || (state_ff == S_NO_EMIT));

   // sequence the operations
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pc_in    = pc_ff;
      qc_in    = qc_ff;
      nid_in   = nid_ff;
      pool_in  = pool_ff;
      holes_in = holes_ff;
      cmd_in   = cmd_ff;
      res_in   = res_ff;
      acc_in   = acc_ff;
      part_in  = part_ff;
      lend_in  = lend_ff;
      pos_in   = pos_ff;
      q_in     = q_ff;
      cmd_pop  = 1'b0;
      pl_we    = 1'b0;
      pl_wa    = idx_ff[AW-1:0];
      pl_wd    = pl_q_ff;
      pn_we    = 1'b0;
      pn_wa    = idx_ff[AW-1:0];
      pn_wd    = pn_q_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               idx_in  = '0;
               acc_in  = '0;
               part_in = '0;
               lend_in = '0;
               pos_in  = '0;
               res_in.id    = '0;
               res_in.start = '1;
               res_in.size  = '0;
               res_in.last  = 1'b1;
               case (cmd.func)
                  acpa_pkg::FUNC_QUEUE: begin
                     if (used_sum >= (CW + 1)'(MAX_CHUNKS)) begin
                        res_in.status = acpa_pkg::ST_FULL;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_Q_DIV;
                     end
                  end
                  acpa_pkg::FUNC_FREE: begin
                     state_in = S_FP_RD;
                  end
                  acpa_pkg::FUNC_FINALIZE: begin
                     state_in = S_NP_RD;
                  end
                  default: begin
                     if ({5'b0, cmd.size} > pool_ff) begin
                        res_in.status = acpa_pkg::ST_TOO_LARGE;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_G_RD;
                     end
                  end
               endcase
            end
         end
         // queue: take the next aligned end above the size, then append
         S_Q_DIV: begin
            q_in     = acpa_pkg::SIZE_W'(div_prod >> DIV_SH);
            state_in = S_Q_MUL;
         end
         S_Q_MUL: begin
            pn_we      = 1'b1;
            pn_wa      = qc_ff[AW-1:0];
            pn_wd.id   = nid_ff;
            pn_wd.size = cmd_ff.size;
            pn_wd.asz  = asz_full[acpa_pkg::ASZ_W-1:0];
            qc_in      = qc_ff + 1'b1;
            nid_in     = nid_ff + 32'd1;
            res_in.status = acpa_pkg::ST_OK;
            res_in.id     = nid_ff;
            res_in.size   = cmd_ff.size;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         // free: search placed table
         S_FP_RD: begin
            if (idx_ff >= pc_ff) begin
               idx_in   = '0;
               state_in = S_FQ_RD;
            end else begin
               state_in = S_FP_CHK;
            end
         end
         S_FP_CHK: begin
            if (pl_q_ff.id == cmd_ff.id) begin
               if (idx_inc < pc_ff) begin
                  holes_in = 1'b1;
               end
               res_in.status = acpa_pkg::ST_OK;
               res_in.id     = cmd_ff.id;
               res_in.start  = $signed({1'b0, pl_q_ff.start});
               res_in.size   = pl_q_ff.size;
               state_in      = S_FPS_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_FP_RD;
            end
         end
         // move later placed entries up by one
         S_FPS_RD: begin
            if (idx_inc < pc_ff) begin
               idx_in   = idx_inc;
               state_in = S_FPS_WT;
            end else begin
               pc_in    = pc_ff - 1'b1;
               state_in = S_EMIT;
            end
         end
         S_FPS_WT: begin
            state_in = S_FPS_WR;
         end
         S_FPS_WR: begin
            pl_we    = 1'b1;
            pl_wa    = AW'(idx_ff - 1'b1);
            pl_wd    = pl_q_ff;
            state_in = S_FPS_RD;
         end
         // free: search pending list
         S_FQ_RD: begin
            if (idx_ff >= qc_ff) begin
               res_in.status = acpa_pkg::ST_UNKNOWN;
               res_in.id     = cmd_ff.id;
               state_in      = S_EMIT;
            end else begin
               state_in = S_FQ_CHK;
            end
         end
         S_FQ_CHK: begin
            if (pn_q_ff.id == cmd_ff.id) begin
               res_in.status = acpa_pkg::ST_OK;
               res_in.id     = cmd_ff.id;
               res_in.size   = pn_q_ff.size;
               state_in      = S_FQS_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_FQ_RD;
            end
         end
         S_FQS_RD: begin
            if (idx_inc < qc_ff) begin
               idx_in   = idx_inc;
               state_in = S_FQS_WT;
            end else begin
               qc_in    = qc_ff - 1'b1;
               state_in = S_EMIT;
            end
         end
         S_FQS_WT: begin
            state_in = S_FQS_WR;
         end
         S_FQS_WR: begin
            pn_we    = 1'b1;
            pn_wa    = AW'(idx_ff - 1'b1);
            pn_wd    = pn_q_ff;
            state_in = S_FQS_RD;
         end
         // finalize: total the placed and pending sizes
         S_NP_RD: begin
            if (idx_ff >= pc_ff) begin
               idx_in   = '0;
               state_in = S_NQ_RD;
            end else begin
               state_in = S_NP_ACC;
            end
         end
         S_NP_ACC: begin
            acc_in   = acc_ff + SW'(pl_q_ff.asz);
            lend_in  = pl_end;
            idx_in   = idx_inc;
            state_in = S_NP_RD;
         end
         S_NQ_RD: begin
            if (idx_ff >= qc_ff) begin
               state_in = S_N_DEC;
            end else begin
               state_in = S_NQ_ACC;
            end
         end
         S_NQ_ACC: begin
            part_in  = part_ff + SW'(pn_q_ff.asz);
            idx_in   = idx_inc;
            state_in = S_NQ_RD;
         end
         // finalize: grow the pool or give up
         S_N_DEC: begin
            idx_in = '0;
            if (newpool > (SW + 1)'(acpa_pkg::POOL_MAX)) begin
               res_in.status = acpa_pkg::ST_NO_SPACE;
               state_in      = S_EMIT;
            end else begin
               pool_in  = newpool[acpa_pkg::POOL_W-1:0];
               pos_in   = '0;
               state_in = holes_ff ? S_NC_RD : S_NA_RD;
               if (!holes_ff) begin
                  pos_in = lend_ff;
               end
            end
         end
         // compact placed entries from zero
         S_NC_RD: begin
            if (idx_ff >= pc_ff) begin
               holes_in = 1'b0;
               idx_in   = '0;
               state_in = S_NA_RD;
            end else begin
               state_in = S_NC_WR;
            end
         end
         S_NC_WR: begin
            pl_we       = 1'b1;
            pl_wd       = pl_q_ff;
            pl_wd.start = pos_ff[acpa_pkg::POOL_W-1:0];
            pos_in      = pos_ff + SW'(pl_q_ff.asz);
            idx_in      = idx_inc;
            state_in    = S_NC_RD;
         end
         // append pending entries at aligned ends
         S_NA_RD: begin
            if (idx_ff >= qc_ff) begin
               qc_in  = '0;
               idx_in = '0;
               if (pc_ff == '0) begin
                  res_in.status = acpa_pkg::ST_OK;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_NO_RD;
               end
            end else begin
               state_in = S_NA_WR;
            end
         end
         S_NA_WR: begin
            pl_we       = 1'b1;
            pl_wa       = pc_ff[AW-1:0];
            pl_wd.id    = pn_q_ff.id;
            pl_wd.start = pos_ff[acpa_pkg::POOL_W-1:0];
            pl_wd.size  = pn_q_ff.size;
            pl_wd.asz   = pn_q_ff.asz;
            pc_in       = pc_ff + 1'b1;
            pos_in      = pos_ff + SW'(pn_q_ff.asz);
            idx_in      = idx_inc;
            state_in    = S_NA_RD;
         end
         // report every placed entry
         S_NO_RD: begin
            state_in = S_NO_EMIT;
         end
         S_NO_EMIT: begin
            if (out_free) begin
               if (idx_inc == pc_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_NO_RD;
               end
            end
         end
         // first-fit gap search
         S_G_RD: begin
            if (idx_ff >= pc_ff) begin
               if (tail_diff < $signed({8'b0, cmd_ff.size})) begin
                  res_in.status = acpa_pkg::ST_NO_SPACE;
               end else begin
                  res_in.status = acpa_pkg::ST_OK;
                  res_in.start  = $signed(pos_ff[acpa_pkg::START_W-1:0]);
               end
               state_in = S_EMIT;
            end else begin
               state_in = S_G_CHK;
            end
         end
         S_G_CHK: begin
            if (gap_diff > $signed({8'b0, cmd_ff.size})) begin
               res_in.status = acpa_pkg::ST_OK;
               res_in.start  = $signed(pos_ff[acpa_pkg::START_W-1:0]);
               state_in      = S_EMIT;
            end else begin
               pos_in   = pl_end;
               idx_in   = idx_inc;
               state_in = S_G_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold or drop the result register
   always_comb begin
      ovalid_in = ovalid_ff;
      if (out_load) begin
         ovalid_in = 1'b1;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         pc_ff     <= '0;
         qc_ff     <= '0;
         nid_ff    <= 32'd1;
         pool_ff   <= '0;
         holes_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         pc_ff     <= pc_in;
         qc_ff     <= qc_in;
         nid_ff    <= nid_in;
         pool_ff   <= pool_in;
         holes_ff  <= holes_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
      acc_ff  <= acc_in;
      part_ff <= part_in;
      lend_ff <= lend_in;
      pos_ff  <= pos_in;
      q_ff    <= q_in;
      if (out_load) begin
         ores_ff  <= emit_res;
         opool_ff <= pool_ff;
      end
   end

   // table memories with registered read
   always_ff @(posedge clock) begin
      if (pl_we) begin
         placed_mem[pl_wa] <= pl_wd;
      end
      pl_q_ff <= placed_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pn_we) begin
         pending_mem[pn_wa] <= pn_wd;
      end
      pn_q_ff <= pending_mem[idx_ff[AW-1:0]];
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = ores_ff.last;
   assign rsp_tdata  = {3'b0, opool_ff, ores_ff.size, ores_ff.start, ores_ff.id,
                        ores_ff.status};

endmodule
`default_nettype wire

@@ rtl/aligned_chunk_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// aligned_chunk_pool_allocator_unit: chunk pool allocator with compaction
// Requests queue, free, finalize or search chunks of a pool whose chunk ends
// are aligned. One item at a time runs through a sequencer over two
// tables of MAX_CHUNKS entries, each with a registered read and a separate
// write port. A free searches the placed table, then the pending list, and
// moves later entries up; a gap search walks the placed entries; finalize
// totals placed and pending sizes, compacts, appends pending entries and
// reports every placed chunk, waiting while the result channel stalls.
// Results leave through an output register, and a two-deep request queue
// takes the next item while one is at work.
// ----------------------------------------------------------------------------
`default_nettype none
module aligned_chunk_pool_allocator_unit #(
   parameter int MAX_CHUNKS  = 32,
   parameter int ALIGN_DW    = 1024,
   parameter int MIN_POOL_DW = 16384
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [acpa_pkg::REQ_W-1:0]  req_tdata,  // func[1:0], size_dw[22:2], item_id[54:23]
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [acpa_pkg::RSP_W-1:0]  rsp_tdata,  // status[2:0], result_id[34:3],
                                                   // start_dw[61:35], chunk_size_dw[82:62],
                                                   // pool_size_dw[108:83]
   output logic                        rsp_tlast
);

   logic              cmd_valid;
   logic              cmd_pop;
   acpa_pkg::cmd_type cmd;

   acpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   acpa_back #(
      .MAX_CHUNKS  (MAX_CHUNKS),
      .ALIGN_DW    (ALIGN_DW),
      .MIN_POOL_DW (MIN_POOL_DW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // engine only takes commands that the queue holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("command taken from empty queue");

   // status codes stay in the defined range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= acpa_pkg::ST_TOO_LARGE))
      else $error("undefined status code");

   // an error result always closes its item
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != acpa_pkg::ST_OK)) |-> rsp_tlast)
      else $error("error result not marked last");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid) else $error("result valid after reset");

endmodule
`default_nettype wire

@@ tb/tb_aligned_chunk_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_aligned_chunk_pool_allocator_unit: self-checking bench of the chunk pool
// Drives queue, free, finalize and gap search requests over the request
// stream. A predictor keeps its own copy of the placed table, the pending list
// and the pool size, and the bench compares every response transfer, field by
// field, with the oldest expected result. A directed table runs first, then
// random traffic under three sender and receiver idle profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_aligned_chunk_pool_allocator_unit;

   localparam int NCHUNK    = 32;
   localparam int ALIGN     = 1024;
   localparam int MIN_POOL  = 16384;
   localparam int SIZE_HI   = 1048576;
   localparam int N_RANDOM  = 190;
   localparam int CYCLE_CAP = 1000000;

   localparam int SIZE_W  = acpa_pkg::SIZE_W;
   localparam int ID_W    = acpa_pkg::ID_W;
   localparam int POOL_W  = acpa_pkg::POOL_W;
   localparam int START_W = acpa_pkg::START_W;
   localparam int REQ_W   = acpa_pkg::REQ_W;
   localparam int RSP_W   = acpa_pkg::RSP_W;

   typedef struct {
      logic [2:0]         status;
      logic [ID_W-1:0]    id;
      logic [START_W-1:0] start;
      logic [SIZE_W-1:0]  size;
      logic [POOL_W-1:0]  pool;
      logic               last;
   } alloc_result_type;

   typedef struct {
      logic [1:0]        func;
      logic [SIZE_W-1:0] size;
      logic [ID_W-1:0]   id;
      bit                typed;
      alloc_result_type  want;
   } stim_row_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tlast;

   // predictor copy of the allocator state
   logic [ID_W-1:0]   tbl_id    [NCHUNK];
   longint            tbl_start [NCHUNK];
   longint            tbl_size  [NCHUNK];
   int                tbl_count;
   logic [ID_W-1:0]   pend_id   [NCHUNK];
   longint            pend_size [NCHUNK];
   int                pend_count;
   logic [ID_W-1:0]   id_counter;
   longint            pool_dw;
   bit                fragmented;

   alloc_result_type  expected_results[$];
   stim_row_type      directed_rows[$];
   int                error_count = 0;
   int                send_gap_pct = 0;
   int                recv_stall_pct = 0;
   longint            cycle_count = 0;

   aligned_chunk_pool_allocator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // randomize receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   function automatic longint align_up(longint x);
      return x + ALIGN - x % ALIGN;
   endfunction

   function automatic alloc_result_type make_result(logic [2:0] st, logic [ID_W-1:0] id,
                                                    longint start, longint size,
                                                    longint pool, bit last);
      alloc_result_type r;
      r.status = st;
      r.id     = id;
      r.start  = start[START_W-1:0];
      r.size   = size[SIZE_W-1:0];
      r.pool   = pool[POOL_W-1:0];
      r.last   = last;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // work out the results of one accepted request and advance the state
   task automatic predict_alloc(logic [1:0] func, logic [SIZE_W-1:0] size,
                                logic [ID_W-1:0] id);
      longint need, part, grown, pos, gap_end;
      int i, j;
      bit found, done;
      found = 0;
      done = 0;
      case (func)
         acpa_pkg::FUNC_QUEUE: begin
            if (tbl_count + pend_count >= NCHUNK) begin
               expected_results.push_back(make_result(acpa_pkg::ST_FULL, 0, -1, 0,
                                                      pool_dw, 1));
            end else begin
               pend_id[pend_count]   = id_counter;
               pend_size[pend_count] = size;
               pend_count++;
               expected_results.push_back(make_result(acpa_pkg::ST_OK, id_counter, -1,
                                                      size, pool_dw, 1));
               id_counter = id_counter + 1;
            end
         end
         acpa_pkg::FUNC_FREE: begin
            for (i = 0; i < tbl_count && !found; i++) begin
               if (tbl_id[i] == id) begin
                  found = 1;
                  expected_results.push_back(make_result(acpa_pkg::ST_OK, id,
                                                         tbl_start[i], tbl_size[i],
                                                         pool_dw, 1));
                  if (i + 1 < tbl_count) fragmented = 1;
                  for (j = i; j + 1 < tbl_count; j++) begin
                     tbl_id[j]    = tbl_id[j + 1];
                     tbl_start[j] = tbl_start[j + 1];
                     tbl_size[j]  = tbl_size[j + 1];
                  end
                  tbl_count--;
               end
            end
            for (i = 0; i < pend_count && !found; i++) begin
               if (pend_id[i] == id) begin
                  found = 1;
                  expected_results.push_back(make_result(acpa_pkg::ST_OK, id, -1,
                                                         pend_size[i], pool_dw, 1));
                  for (j = i; j + 1 < pend_count; j++) begin
                     pend_id[j]   = pend_id[j + 1];
                     pend_size[j] = pend_size[j + 1];
                  end
                  pend_count--;
               end
            end
            if (!found)
               expected_results.push_back(make_result(acpa_pkg::ST_UNKNOWN, id, -1, 0,
                                                      pool_dw, 1));
         end
         acpa_pkg::FUNC_FINALIZE: begin
            need = 0;
            part = 0;
            for (i = 0; i < tbl_count; i++) need = align_up(need + tbl_size[i]);
            for (i = 0; i < pend_count; i++) part = align_up(part + pend_size[i]);
            need += part;
            grown = pool_dw;
            if (pool_dw < need)
               grown = (pool_dw == 0) ? ((need > MIN_POOL) ? need : MIN_POOL)
                                      : align_up(need);
            if (grown > longint'(acpa_pkg::POOL_MAX)) begin
               expected_results.push_back(make_result(acpa_pkg::ST_NO_SPACE, 0, -1, 0,
                                                      pool_dw, 1));
            end else begin
               // close holes before appending
               if (fragmented) begin
                  pos = 0;
                  for (i = 0; i < tbl_count; i++) begin
                     tbl_start[i] = pos;
                     pos = align_up(pos + tbl_size[i]);
                  end
                  fragmented = 0;
               end
               pool_dw = grown;
               pos = 0;
               if (tbl_count > 0)
                  pos = align_up(tbl_start[tbl_count - 1] + tbl_size[tbl_count - 1]);
               for (i = 0; i < pend_count && tbl_count < NCHUNK; i++) begin
                  tbl_id[tbl_count]    = pend_id[i];
                  tbl_size[tbl_count]  = pend_size[i];
                  tbl_start[tbl_count] = pos & longint'(acpa_pkg::POOL_MAX);
                  tbl_count++;
                  pos = align_up(pos + pend_size[i]);
               end
               pend_count = 0;
               if (tbl_count == 0)
                  expected_results.push_back(make_result(acpa_pkg::ST_OK, 0, -1, 0,
                                                         pool_dw, 1));
               for (i = 0; i < tbl_count; i++)
                  expected_results.push_back(make_result(acpa_pkg::ST_OK, tbl_id[i],
                                                         tbl_start[i], tbl_size[i],
                                                         pool_dw, i + 1 == tbl_count));
            end
         end
         default: begin
            if (longint'(size) > pool_dw) begin
               expected_results.push_back(make_result(acpa_pkg::ST_TOO_LARGE, 0, -1, 0,
                                                      pool_dw, 1));
            end else begin
               gap_end = 0;
               for (i = 0; i < tbl_count && !done; i++) begin
                  if (tbl_start[i] - gap_end > longint'(size)) begin
                     done = 1;
                  end else begin
                     gap_end = align_up(tbl_start[i] + tbl_size[i]);
                  end
               end
               if (!done && pool_dw - gap_end < longint'(size))
                  expected_results.push_back(make_result(acpa_pkg::ST_NO_SPACE, 0, -1, 0,
                                                         pool_dw, 1));
               else
                  expected_results.push_back(make_result(acpa_pkg::ST_OK, 0, gap_end, 0,
                                                         pool_dw, 1));
            end
         end
      endcase
   endtask

   // hold one request until it is accepted; typed rows replace the prediction
   task automatic send_request(logic [1:0] func, logic [SIZE_W-1:0] size,
                               logic [ID_W-1:0] id, bit typed, alloc_result_type want);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, id, size, func};
      do @(posedge clock); while (!req_tready);
      predict_alloc(func, size, id);
      if (typed) begin
         expected_results.pop_back();
         expected_results.push_back(want);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // compare every response transfer with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[2:0], 0);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[2:0] !== exp_r.status)
               report_mismatch("status", rsp_tdata[2:0], exp_r.status);
            if (rsp_tdata[34:3] !== exp_r.id)
               report_mismatch("result_id", rsp_tdata[34:3], exp_r.id);
            if (rsp_tdata[61:35] !== exp_r.start)
               report_mismatch("start_dw", rsp_tdata[61:35], exp_r.start);
            if (rsp_tdata[82:62] !== exp_r.size)
               report_mismatch("chunk_size_dw", rsp_tdata[82:62], exp_r.size);
            if (rsp_tdata[108:83] !== exp_r.pool)
               report_mismatch("pool_size_dw", rsp_tdata[108:83], exp_r.pool);
            if (rsp_tlast !== exp_r.last)
               report_mismatch("tlast", rsp_tlast, exp_r.last);
         end
      end
   end

   task automatic add_row(logic [1:0] func, longint size, logic [ID_W-1:0] id,
                          bit typed = 0, logic [2:0] st = acpa_pkg::ST_OK,
                          logic [ID_W-1:0] rid = 0, longint start = -1,
                          longint csize = 0);
      stim_row_type row;
      row.func  = func;
      row.size  = size[SIZE_W-1:0];
      row.id    = id;
      row.typed = typed;
      row.want  = make_result(st, rid, start, csize, 0, 1);
      directed_rows.push_back(row);
   endtask

   // pick a random request, mostly well formed
   task automatic send_random();
      int pick, total, span;
      logic [1:0] func;
      logic [SIZE_W-1:0] size;
      logic [ID_W-1:0] id;
      alloc_result_type none;
      none = make_result(acpa_pkg::ST_OK, 0, -1, 0, 0, 1);
      pick = $urandom_range(0, 99);
      id = $urandom;
      if ($urandom_range(0, 9) < 8) size = SIZE_W'($urandom_range(0, 6000));
      else if ($urandom_range(0, 3) == 0) size = SIZE_W'(SIZE_HI);
      else size = SIZE_W'($urandom_range(0, SIZE_HI));
      if (pick < 40) begin
         func = acpa_pkg::FUNC_QUEUE;
      end else if (pick < 65) begin
         func = acpa_pkg::FUNC_FREE;
         total = tbl_count + pend_count;
         if (total > 0 && $urandom_range(0, 9) < 8) begin
            pick = $urandom_range(0, total - 1);
            id = (pick < tbl_count) ? tbl_id[pick] : pend_id[pick - tbl_count];
         end
      end else if (pick < 80) begin
         func = acpa_pkg::FUNC_FINALIZE;
      end else begin
         func = acpa_pkg::FUNC_SEARCH;
         if ($urandom_range(0, 3) != 0 && pool_dw > 0) begin
            span = (pool_dw > SIZE_HI) ? SIZE_HI : int'(pool_dw);
            size = SIZE_W'($urandom_range(0, span));
         end
      end
      send_request(func, size, id, 0, none);
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      int k;
      tbl_count  = 0;
      pend_count = 0;
      id_counter = 1;
      pool_dw    = 0;
      fragmented = 0;

      // directed cases: empty pool, extremes, holes and compaction
      add_row(acpa_pkg::FUNC_SEARCH,   1, 0, 1, acpa_pkg::ST_TOO_LARGE, 0, -1, 0);
      add_row(acpa_pkg::FUNC_SEARCH,   0, 0);
      add_row(acpa_pkg::FUNC_FINALIZE, 0, 0, 1, acpa_pkg::ST_OK, 0, -1, 0);
      add_row(acpa_pkg::FUNC_FREE,     0, 32'hFFFF_FFFF, 1, acpa_pkg::ST_UNKNOWN,
              32'hFFFF_FFFF, -1, 0);
      add_row(acpa_pkg::FUNC_QUEUE,    0, 0, 1, acpa_pkg::ST_OK, 1, -1, 0);
      add_row(acpa_pkg::FUNC_QUEUE,    SIZE_HI, 0, 1, acpa_pkg::ST_OK, 2, -1, SIZE_HI);
      add_row(acpa_pkg::FUNC_QUEUE,    1023, 0);
      add_row(acpa_pkg::FUNC_QUEUE,    1024, 0);
      add_row(acpa_pkg::FUNC_QUEUE,    5000, 0);
      add_row(acpa_pkg::FUNC_FREE,     0, 4);
      add_row(acpa_pkg::FUNC_FINALIZE, 0, 0);
      add_row(acpa_pkg::FUNC_FREE,     0, 2);
      add_row(acpa_pkg::FUNC_SEARCH,   1000, 0);
      add_row(acpa_pkg::FUNC_SEARCH,   SIZE_HI, 0);
      add_row(acpa_pkg::FUNC_FINALIZE, 0, 0);
      add_row(acpa_pkg::FUNC_FREE,     0, 5);
      add_row(acpa_pkg::FUNC_SEARCH,   0, 0);
      add_row(acpa_pkg::FUNC_FREE,     0, 2);
      add_row(acpa_pkg::FUNC_QUEUE,    1, 32'hFFFF_FFFF);
      add_row(acpa_pkg::FUNC_SEARCH,   2047, 0);
      add_row(acpa_pkg::FUNC_FINALIZE, 0, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, first idle profile
      send_gap_pct   = 6;
      recv_stall_pct = 68;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].typed) directed_rows[r].want.pool = pool_dw[POOL_W-1:0];
         send_request(directed_rows[r].func, directed_rows[r].size, directed_rows[r].id,
                      directed_rows[r].typed, directed_rows[r].want);
      end

      // random part over three idle profiles
      for (k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM / 3) begin
            // hold the sender until the block has drained
            wait_drained();
            send_gap_pct   = 68;
            recv_stall_pct = 6;
         end else if (k == 2 * N_RANDOM / 3) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         send_random();
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/acpa_pkg.sv
rtl/acpa_front.sv
rtl/acpa_back.sv
rtl/aligned_chunk_pool_allocator_unit.sv
tb/tb_aligned_chunk_pool_allocator_unit.sv
